[rtl/core/numa_fallback_order_table_assert.svh]
// Assertion macros shared by the checker.
`ifndef NUMA_FALLBACK_ORDER_TABLE_ASSERT_SVH
`define NUMA_FALLBACK_ORDER_TABLE_ASSERT_SVH

`define NFOT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define NFOT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/nfot_pkg.sv]
`default_nettype none
package nfot_pkg;
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned DistW    = 8;
  localparam int unsigned RawW     = 16;
  localparam int unsigned AddrW    = 2 * NodeW;
  localparam int unsigned Depth    = MaxNodes * MaxNodes;
  localparam int unsigned PaddrW   = 3;

  typedef enum logic [1:0] {
    CmdWrDist = 2'd0,
    CmdBuild  = 2'd1,
    CmdRdRank = 2'd2,
    CmdRdDist = 2'd3
  } cmd_e;

  localparam logic [DistW-1:0] DistMax = 8'd255;
  localparam logic [CountW-1:0] NodeCntMax = 7'd64;
  localparam logic [CountW-1:0] NodeCntRst = 7'd1;
endpackage
`default_nettype wire

[rtl/core/numa_fallback_order_table.sv]
`default_nettype none
// NUMA fallback order table.
// Commands enter on start/cmd_i and are taken when busy is low. Each
// command gives one transaction on result_valid_o, valid for one cycle;
// the receiver cannot stall it.
// Distance write, rank read and distance read keep busy low: the result
// shows in the cycle after acceptance and a new command may be taken
// every cycle while busy is low; each table memory has one read port.
// A rebuild (command 1) sorts every active row by counting, for each node,
// how many nodes rank ahead of it; it keeps busy high while it steps
// through each active row and node, reading the distance memory once per
// cycle. The result follows the last order write.
// The active node count lives on the APB port at address 0 (reset value 1).
// After reset both tables are cleared, one entry per cycle, all 4096
// entries, while busy stays high; configuration writes are taken meanwhile.
module numa_fallback_order_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [nfot_pkg::NodeW-1:0]    from_node_i,
  input  wire logic [nfot_pkg::NodeW-1:0]    to_node_i,
  input  wire logic [nfot_pkg::NodeW-1:0]    rank_i,
  input  wire logic [nfot_pkg::RawW-1:0]     distance_value_i,
  output logic                               result_valid_o,
  output logic [nfot_pkg::NodeW-1:0]         result_node_o,
  output logic [nfot_pkg::DistW-1:0]         result_distance_o,
  output logic                               done_res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nfot_pkg::PaddrW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  typedef enum logic [2:0] {
    StClear, StIdle, StLoadJ, StLatchJ, StScan
  } state_e;

  localparam int unsigned NW = nfot_pkg::NodeW;
  localparam int unsigned CW = nfot_pkg::CountW;
  localparam int unsigned AW = nfot_pkg::AddrW;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [CW-1:0]       nodes_q;
  logic [NW-1:0]       src_q, j_q, pend_k_q, cnt_q;
  logic [CW-1:0]       kiss_q;
  logic [nfot_pkg::DistW-1:0] dj_q;
  logic                out_vld_q, out_byp_q;
  nfot_pkg::cmd_e      out_cmd_q;
  logic [NW-1:0]       out_from_q;

  logic [CW-1:0]       n_eff;
  logic                accept;
  nfot_pkg::cmd_e      cmd;
  logic                inc;
  logic [NW-1:0]       cnt_d;
  logic [CW-1:0]       j_nxt, src_nxt;

  logic                   d_we, o_we;
  logic [AW-1:0]          d_waddr, d_raddr, o_waddr, o_raddr;
  logic [nfot_pkg::DistW-1:0] d_wdata, d_rdata;
  logic [NW-1:0]          o_wdata, o_rdata;

  assign cmd    = nfot_pkg::cmd_e'(cmd_i);
  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign n_eff  = (nodes_q > nfot_pkg::NodeCntMax) ? nfot_pkg::NodeCntMax : nodes_q;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CW){1'b0}}, nodes_q};

  assign inc   = (d_rdata < dj_q) || ((d_rdata == dj_q) && (pend_k_q < j_q));
  assign cnt_d = cnt_q + {{(NW - 1){1'b0}}, inc};
  assign j_nxt   = {1'b0, j_q} + CW'(1);
  assign src_nxt = {1'b0, src_q} + CW'(1);

  always_comb begin
    d_we    = 1'b0;
    d_waddr = {from_node_i, to_node_i};
    d_wdata = (distance_value_i > {8'd0, nfot_pkg::DistMax}) ? nfot_pkg::DistMax
                                                            : distance_value_i[7:0];
    d_raddr = {from_node_i, to_node_i};
    o_we    = 1'b0;
    o_waddr = {src_q, cnt_d};
    o_wdata = j_q;
    o_raddr = {from_node_i, rank_i};
    unique case (state_q)
      StClear: begin
        d_we    = 1'b1;
        d_waddr = clr_q;
        d_wdata = '0;
        o_we    = 1'b1;
        o_waddr = clr_q;
        o_wdata = '0;
      end
      StIdle: begin
        d_we = accept && (cmd == nfot_pkg::CmdWrDist);
      end
      StLoadJ:  d_raddr = {src_q, j_q};
      StLatchJ: d_raddr = {src_q, {NW{1'b0}}};
      StScan: begin
        d_raddr = {src_q, kiss_q[NW-1:0]};
        o_we    = (kiss_q == n_eff);
      end
      default: ;
    endcase
  end

  nfot_ram #(.Width(nfot_pkg::DistW), .Depth(nfot_pkg::Depth)) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  nfot_ram #(.Width(NW), .Depth(nfot_pkg::Depth)) u_order_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .raddr_i(o_raddr),
    .rdata_o(o_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= nfot_pkg::NodeCntRst;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      nodes_q <= pwdata[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
      out_cmd_q  <= nfot_pkg::CmdWrDist;
      out_from_q <= '0;
      out_byp_q  <= 1'b0;
      src_q      <= '0;
      j_q        <= '0;
      kiss_q     <= '0;
      dj_q       <= '0;
      cnt_q      <= '0;
      pend_k_q   <= '0;
    end else begin
      out_vld_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AW'(1);
          if (&clr_q) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            out_cmd_q  <= cmd;
            out_from_q <= from_node_i;
            out_byp_q  <= ({1'b0, from_node_i} >= n_eff) || ({1'b0, rank_i} >= n_eff);
            if (cmd == nfot_pkg::CmdBuild && n_eff != '0) begin
              src_q   <= '0;
              j_q     <= '0;
              state_q <= StLoadJ;
            end else begin
              out_vld_q <= 1'b1;
            end
          end
        end
        StLoadJ: state_q <= StLatchJ;
        StLatchJ: begin
          dj_q     <= d_rdata;
          cnt_q    <= '0;
          pend_k_q <= '0;
          kiss_q   <= {{(CW - 1){1'b0}}, 1'b1};
          state_q  <= StScan;
        end
        StScan: begin
          cnt_q <= cnt_d;
          if (kiss_q != n_eff) begin
            pend_k_q <= kiss_q[NW-1:0];
            kiss_q   <= kiss_q + CW'(1);
          end else if (j_nxt < n_eff) begin
            j_q     <= j_nxt[NW-1:0];
            state_q <= StLoadJ;
          end else if (src_nxt < n_eff) begin
            j_q     <= '0;
            src_q   <= src_nxt[NW-1:0];
            state_q <= StLoadJ;
          end else begin
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o    = out_vld_q;
  assign done_res_o        = out_vld_q;
  assign result_node_o     = (out_vld_q && out_cmd_q == nfot_pkg::CmdRdRank)
                             ? (out_byp_q ? out_from_q : o_rdata) : '0;
  assign result_distance_o = (out_vld_q && out_cmd_q == nfot_pkg::CmdRdDist) ? d_rdata : '0;
endmodule
`default_nettype wire

[rtl/core/nfot_ram.sv]
`default_nettype none
module nfot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/core/nfot_checker.sv]
`default_nettype none
`include "numa_fallback_order_table_assert.svh"
module nfot_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [1:0]                  cmd_i,
  input wire logic                        result_valid_o,
  input wire logic [nfot_pkg::NodeW-1:0]  result_node_o,
  input wire logic [nfot_pkg::DistW-1:0]  result_distance_o,
  input wire logic                        done_res_o
);
  logic take, wr_take, quiet;

  assign take    = start && !busy;
  assign wr_take = take && (cmd_i == nfot_pkg::CmdWrDist);
  assign quiet   = (result_node_o == '0) && (result_distance_o == '0);

  `NFOT_ASSERT_NXT(a_read_one_cycle, clk_i, rst_ni, take && cmd_i[1], result_valid_o)
  `NFOT_ASSERT_NXT(a_write_zero, clk_i, rst_ni, wr_take, result_valid_o && quiet)
  `NFOT_ASSERT_IMP(a_done_marks, clk_i, rst_ni, result_valid_o, done_res_o)
  `NFOT_ASSERT_IMP(a_idle_quiet, clk_i, rst_ni, !result_valid_o, quiet)
endmodule

bind numa_fallback_order_table nfot_checker u_nfot_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .cmd_i            (cmd_i),
  .result_valid_o   (result_valid_o),
  .result_node_o    (result_node_o),
  .result_distance_o(result_distance_o),
  .done_res_o       (done_res_o)
);
`default_nettype wire
